// ===== design/ecb_pkg.sv =====
// ecb_pkg: shared constants, codes and types for the error count circuit breaker
// used by every file in design/, depends on nothing
package ecb_pkg;

   localparam int ENTRIES        = 32;
   localparam int IDX_BITS       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int TIME_BITS      = 48;
   localparam int MAX_RESULTS    = 32;
   localparam int RES_BITS       = $clog2(MAX_RESULTS + 1);

   localparam int MODE_BITS      = 2;
   localparam int ENTRY_BITS     = 5;
   localparam int CNT_BITS       = 16;
   localparam int SLEEP_BITS     = 32;
   localparam int TIMEOUT_FACTOR = 100;
   localparam int TIMEOUT_BITS   = SLEEP_BITS + $clog2(TIMEOUT_FACTOR);
   localparam int CMP_BITS       = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

   localparam int REQ_DATA_BITS  = ((ENTRY_BITS + 1 + TIME_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((ENTRY_BITS + 2 + 1 + 7) / 8) * 8;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CNT_BITS-1:0]   CNT_MAX       = {CNT_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0]   DEF_THRESHOLD = 16'd10;
   localparam logic [SLEEP_BITS-1:0] DEF_SLEEP     = 32'd30000;
   localparam logic [CNT_BITS-1:0]   DEF_PROBE     = 16'd10;
   localparam logic [CNT_BITS-1:0]   DEF_CLOSE     = 16'd8;

   // item kinds carried on req_tuser
   localparam logic [MODE_BITS-1:0] MODE_CALL  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SWEEP = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PROBE = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_ERROR_THRESHOLD = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SLEEP_WINDOW    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PROBE_COUNT     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CLOSE_COUNT     = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_AUTO_HALF_OPEN  = 3'd4;

   typedef enum logic [1:0] {
      ST_CLOSED = 2'd0,
      ST_OPEN   = 2'd1,
      ST_HALF   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FLUSH
   } state_type;

   // effective configuration, defaults and clamps already applied
   typedef struct packed {
      logic [CNT_BITS-1:0]     threshold;
      logic [SLEEP_BITS-1:0]   sleep;
      logic [CNT_BITS-1:0]     close;
      logic [CNT_BITS:0]       half_limit;
      logic [TIMEOUT_BITS-1:0] timeout;
      logic                    auto_half_open;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic read;
      logic commit;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic req_ok;
      logic sweep;
      logic last_entry;
      logic eval_stall;
      logic pend_valid;
      logic out_free;
   } stat_type;

endpackage

// ===== design/error_count_circuit_breaker_top.sv =====
// error_count_circuit_breaker_top: circuit breaker over a table of targets
// depends on ecb_pkg, ecb_cfg, ecb_ctrl, ecb_dpath
//
//   channel   ports        word
//   ------------------------------------------------------------------
//   request   req_t*       tuser mode; tdata entry_index, call_failed, now_ms
//   result    rsp_t*       tdata out_entry, new_status, changed; tlast last
//   config    csr_*        write enable, register index, write data
//
// call result and probe: the item steps through read, evaluate and flush, and the result word
// is loaded at flush; the next word is taken once the sequencer is back in idle;
// a sweep reads, evaluates and writes back each entry in turn, then flushes;
// the single-port read-modify-write of the table sets this order, one entry at a time
// reset clears the table and counters directly, no clearing pass
// a held result stalls evaluation only when a second result is ready behind it
module error_count_circuit_breaker_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ecb_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // entry_index, call_failed, now_ms
   input  logic [ecb_pkg::MODE_BITS-1:0]       req_tuser,  // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ecb_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // out_entry, new_status, changed
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [ecb_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [ecb_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   ecb_pkg::cfg_type  cfg;
   ecb_pkg::cmd_type  cmd;
   ecb_pkg::stat_type stat;

   ecb_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ecb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ecb_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg        (cfg),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // nothing of the previous item may be held back once a new one can come in
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stat.pend_valid && !cmd.commit)
      else $error("pending result left when ready for a new word");

   a_flush_room: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> stat.out_free && stat.pend_valid)
      else $error("flush without a free output slot");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.eval_stall)
      else $error("write back while a result would be dropped");

   a_flush_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> req_tready && !rsp_tvalid || req_tready)
      else $error("sequencer not idle after flush");
`endif

endmodule

// ===== design/ecb_cfg.sv =====
// ecb_cfg: configuration registers and the effective values derived from them
// depends on ecb_pkg
module ecb_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ecb_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [ecb_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output ecb_pkg::cfg_type                    cfg
);

   logic [ecb_pkg::CNT_BITS-1:0]   threshold_ff;
   logic [ecb_pkg::SLEEP_BITS-1:0] sleep_ff;
   logic [ecb_pkg::CNT_BITS-1:0]   probe_ff;
   logic [ecb_pkg::CNT_BITS-1:0]   close_ff;
   logic                           auto_ff;

   logic [ecb_pkg::CNT_BITS-1:0]   eff_probe;
   logic [ecb_pkg::CNT_BITS-1:0]   eff_close_raw;
   ecb_pkg::cfg_type               cfg_in;
   ecb_pkg::cfg_type               cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ecb_pkg::DEF_THRESHOLD;
         sleep_ff     <= ecb_pkg::DEF_SLEEP;
         probe_ff     <= ecb_pkg::DEF_PROBE;
         close_ff     <= ecb_pkg::DEF_CLOSE;
         auto_ff      <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            ecb_pkg::REG_ERROR_THRESHOLD: begin
               threshold_ff <= csr_wdata[ecb_pkg::CNT_BITS-1:0];
            end
            ecb_pkg::REG_SLEEP_WINDOW: begin
               sleep_ff <= csr_wdata[ecb_pkg::SLEEP_BITS-1:0];
            end
            ecb_pkg::REG_PROBE_COUNT: begin
               probe_ff <= csr_wdata[ecb_pkg::CNT_BITS-1:0];
            end
            ecb_pkg::REG_CLOSE_COUNT: begin
               close_ff <= csr_wdata[ecb_pkg::CNT_BITS-1:0];
            end
            ecb_pkg::REG_AUTO_HALF_OPEN: begin
               auto_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // a zero threshold, sleep, probe or close register falls back to its default
   always_comb begin
      eff_probe     = (probe_ff != '0) ? probe_ff : ecb_pkg::DEF_PROBE;
      eff_close_raw = (close_ff != '0) ? close_ff : ecb_pkg::DEF_CLOSE;
      cfg_in.threshold = (threshold_ff != '0) ? threshold_ff : ecb_pkg::DEF_THRESHOLD;
      cfg_in.sleep     = (sleep_ff != '0) ? sleep_ff : ecb_pkg::DEF_SLEEP;
      cfg_in.close     = (eff_close_raw > eff_probe) ? eff_probe : eff_close_raw;
      cfg_in.half_limit = {1'b0, eff_probe} - {1'b0, cfg_in.close} + 1'b1;
      cfg_in.timeout   = ecb_pkg::TIMEOUT_BITS'(cfg_in.sleep)
                         * ecb_pkg::TIMEOUT_BITS'(ecb_pkg::TIMEOUT_FACTOR);
      cfg_in.auto_half_open = auto_ff;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/ecb_dpath.sv =====
// ecb_dpath: entry table, read and evaluate stages, pending result and output register
// depends on ecb_pkg, driven by ecb_ctrl commands
module ecb_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ecb_pkg::cmd_type                     cmd,
   output ecb_pkg::stat_type                    stat,
   input  ecb_pkg::cfg_type                     cfg,
   input  logic [ecb_pkg::MODE_BITS-1:0]        req_tuser,
   input  logic [ecb_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [ecb_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                 rsp_tlast
);

   logic [ecb_pkg::ENTRY_BITS-1:0] req_entry;
   logic                           req_failed;
   logic [ecb_pkg::TIME_BITS-1:0]  req_now;
   logic                           req_sweep;

   // item registers
   logic [ecb_pkg::MODE_BITS-1:0]  mode_ff;
   logic                           failed_ff;
   logic [ecb_pkg::TIME_BITS-1:0]  now_ff;
   logic [ecb_pkg::IDX_BITS-1:0]   idx_ff;

   // entry table
   ecb_pkg::status_type            status_ff [ecb_pkg::ENTRIES];
   logic [ecb_pkg::CNT_BITS-1:0]   err_ff    [ecb_pkg::ENTRIES];
   logic [ecb_pkg::CNT_BITS-1:0]   suc_ff    [ecb_pkg::ENTRIES];
   logic [ecb_pkg::TIME_BITS-1:0]  time_ff   [ecb_pkg::ENTRIES];

   // read stage
   logic [ecb_pkg::TIME_BITS:0]    rd_diff;
   ecb_pkg::status_type            rd_status_ff;
   logic [ecb_pkg::CNT_BITS-1:0]   rd_err_ff;
   logic [ecb_pkg::CNT_BITS-1:0]   rd_suc_ff;
   logic [ecb_pkg::TIME_BITS-1:0]  rd_delta_ff;
   logic                           rd_behind_ff;

   // evaluate stage
   logic                           sleep_ok;
   logic                           timeout_ok;
   logic [ecb_pkg::CNT_BITS-1:0]   err_inc;
   logic [ecb_pkg::CNT_BITS-1:0]   suc_inc;
   ecb_pkg::status_type            ev_status;
   logic [ecb_pkg::CNT_BITS-1:0]   ev_err;
   logic [ecb_pkg::CNT_BITS-1:0]   ev_suc;
   logic                           ev_set_time;
   logic                           ev_changed;
   logic                           ev_record;

   // pending result and output word
   logic                           pend_valid_ff;
   logic [ecb_pkg::IDX_BITS-1:0]   pend_idx_ff;
   ecb_pkg::status_type            pend_status_ff;
   logic                           pend_changed_ff;
   logic [ecb_pkg::RES_BITS-1:0]   res_cnt_ff;
   logic                           emit_old;
   logic                           out_free;
   logic                           rsp_valid_ff;
   logic [ecb_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                           rsp_last_ff;

   assign req_entry  = req_tdata[ecb_pkg::ENTRY_BITS-1:0];
   assign req_failed = req_tdata[ecb_pkg::ENTRY_BITS];
   assign req_now    = req_tdata[ecb_pkg::ENTRY_BITS+1 +: ecb_pkg::TIME_BITS];
   assign req_sweep  = (req_tuser == ecb_pkg::MODE_SWEEP);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_tuser;
         failed_ff <= req_failed;
         now_ff    <= req_now;
         idx_ff    <= req_sweep ? '0 : ecb_pkg::IDX_BITS'(req_entry);
      end else if (cmd.commit && !stat.last_entry) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // borrow out of the subtract says now is behind the change time
   assign rd_diff = {1'b0, now_ff} - {1'b0, time_ff[idx_ff]};

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_status_ff <= status_ff[idx_ff];
         rd_err_ff    <= err_ff[idx_ff];
         rd_suc_ff    <= suc_ff[idx_ff];
         rd_delta_ff  <= rd_diff[ecb_pkg::TIME_BITS-1:0];
         rd_behind_ff <= rd_diff[ecb_pkg::TIME_BITS];
      end
   end

   always_comb begin
      sleep_ok   = !rd_behind_ff && (ecb_pkg::CMP_BITS'(rd_delta_ff)
                                     >= ecb_pkg::CMP_BITS'(cfg.sleep));
      timeout_ok = !rd_behind_ff && (ecb_pkg::CMP_BITS'(rd_delta_ff)
                                     >= ecb_pkg::CMP_BITS'(cfg.timeout));
      err_inc = (rd_err_ff != ecb_pkg::CNT_MAX) ? rd_err_ff + 1'b1 : rd_err_ff;
      suc_inc = (rd_suc_ff != ecb_pkg::CNT_MAX) ? rd_suc_ff + 1'b1 : rd_suc_ff;

      ev_status   = rd_status_ff;
      ev_err      = rd_err_ff;
      ev_suc      = rd_suc_ff;
      ev_set_time = 1'b0;

      case (mode_ff)
         ecb_pkg::MODE_SWEEP: begin
            case (rd_status_ff)
               ecb_pkg::ST_OPEN: begin
                  if (cfg.auto_half_open && sleep_ok) begin
                     ev_status   = ecb_pkg::ST_HALF;
                     ev_err      = '0;
                     ev_suc      = '0;
                     ev_set_time = 1'b1;
                  end
               end
               ecb_pkg::ST_HALF: begin
                  if (rd_suc_ff >= cfg.close) begin
                     ev_status   = ecb_pkg::ST_CLOSED;
                     ev_err      = '0;
                     ev_set_time = 1'b1;
                  end else if (timeout_ok) begin
                     ev_status   = ecb_pkg::ST_OPEN;
                     ev_set_time = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ecb_pkg::MODE_CALL: begin
            if (failed_ff) begin
               case (rd_status_ff)
                  ecb_pkg::ST_CLOSED: begin
                     ev_err = err_inc;
                     if (err_inc >= cfg.threshold) begin
                        ev_status   = ecb_pkg::ST_OPEN;
                        ev_set_time = 1'b1;
                     end
                  end
                  ecb_pkg::ST_HALF: begin
                     ev_err = err_inc;
                     if ({1'b0, err_inc} >= cfg.half_limit) begin
                        ev_status   = ecb_pkg::ST_OPEN;
                        ev_set_time = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (rd_status_ff == ecb_pkg::ST_HALF) begin
               ev_suc = suc_inc;
            end else begin
               ev_err = '0;
            end
         end
         ecb_pkg::MODE_PROBE: begin
            if (rd_status_ff == ecb_pkg::ST_OPEN) begin
               ev_status   = ecb_pkg::ST_HALF;
               ev_err      = '0;
               ev_suc      = '0;
               ev_set_time = 1'b1;
            end
         end
         default: begin
         end
      endcase

      ev_changed = (ev_status != rd_status_ff);
      // a sweep reports only changed entries, up to the result cap
      ev_record  = (mode_ff != ecb_pkg::MODE_SWEEP)
                   || (ev_changed && (res_cnt_ff < ecb_pkg::RES_BITS'(ecb_pkg::MAX_RESULTS)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ecb_pkg::ENTRIES; i++) begin
            status_ff[i] <= ecb_pkg::ST_CLOSED;
            err_ff[i]    <= '0;
            suc_ff[i]    <= '0;
            time_ff[i]   <= '0;
         end
      end else if (cmd.commit) begin
         status_ff[idx_ff] <= ev_status;
         err_ff[idx_ff]    <= ev_err;
         suc_ff[idx_ff]    <= ev_suc;
         if (ev_set_time) begin
            time_ff[idx_ff] <= now_ff;
         end
      end
   end

   // newest result is held back so the final one of an item can carry tlast
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit_old = cmd.commit && ev_record && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         res_cnt_ff    <= '0;
      end else begin
         if (cmd.load) begin
            res_cnt_ff <= '0;
         end else if (cmd.commit && ev_record) begin
            res_cnt_ff <= res_cnt_ff + 1'b1;
         end
         if (cmd.commit && ev_record) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && ev_record) begin
         pend_idx_ff     <= idx_ff;
         pend_status_ff  <= ev_status;
         pend_changed_ff <= ev_changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_old || cmd.flush) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_old || cmd.flush) begin
         rsp_data_ff <= ecb_pkg::RSP_DATA_BITS'({pend_changed_ff, pend_status_ff,
                                                ecb_pkg::ENTRY_BITS'(pend_idx_ff)});
         rsp_last_ff <= cmd.flush;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      stat.req_ok     = req_sweep
                        || (((req_tuser == ecb_pkg::MODE_CALL) || (req_tuser == ecb_pkg::MODE_PROBE))
                            && (32'(req_entry) < 32'(ecb_pkg::ENTRIES)));
      stat.sweep      = (mode_ff == ecb_pkg::MODE_SWEEP);
      stat.last_entry = (idx_ff == ecb_pkg::IDX_BITS'(ecb_pkg::ENTRIES - 1));
      stat.eval_stall = ev_record && pend_valid_ff && !out_free;
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = out_free;
   end

endmodule

// ===== design/ecb_ctrl.sv =====
// ecb_ctrl: sequencer that steps one item through read, evaluate and flush
// depends on ecb_pkg, commands ecb_dpath
module ecb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ecb_pkg::stat_type  stat,
   output ecb_pkg::cmd_type   cmd
);

   ecb_pkg::state_type state_ff;
   ecb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ecb_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               // ignored items are loaded but leave no trace in the table or on the result port
               if (stat.req_ok) begin
                  state_in = ecb_pkg::S_READ;
               end
            end
         end
         ecb_pkg::S_READ: begin
            cmd.read = 1'b1;
            state_in = ecb_pkg::S_EVAL;
         end
         ecb_pkg::S_EVAL: begin
            if (!stat.eval_stall) begin
               cmd.commit = 1'b1;
               if (stat.sweep && !stat.last_entry) begin
                  state_in = ecb_pkg::S_READ;
               end else begin
                  state_in = ecb_pkg::S_FLUSH;
               end
            end
         end
         ecb_pkg::S_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = ecb_pkg::S_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ecb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ecb_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/ecb_checker.sv =====
// ecb_checker: watches the request, result and register ports of the circuit breaker,
// keeps its own copy of the breaker table and compares every result word in order
// depends on ecb_pkg
module ecb_checker
   import ecb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // entry_index, call_failed, now_ms
   input  logic [MODE_BITS-1:0]     req_tuser,  // mode
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,  // out_entry, new_status, changed
   input  logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatch_count,
   output int                       reports_due
);

   typedef struct packed {
      logic [ENTRY_BITS-1:0] entry;
      status_type            status;
      logic                  changed;
      logic                  last;
   } status_report_type;

   status_type            entry_state [ENTRIES];
   logic [CNT_BITS-1:0]   fail_run    [ENTRIES];
   logic [CNT_BITS-1:0]   pass_run    [ENTRIES];
   logic [TIME_BITS-1:0]  state_since [ENTRIES];

   logic [CNT_BITS-1:0]   cfg_threshold;
   logic [SLEEP_BITS-1:0] cfg_sleep;
   logic [CNT_BITS-1:0]   cfg_probe;
   logic [CNT_BITS-1:0]   cfg_close;
   logic                  cfg_auto_half;

   status_report_type     status_reports [$];

   function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // true once now is at least span past since; never when time ran backward
   function automatic bit window_passed(input logic [TIME_BITS-1:0] since_ms,
                                        input logic [TIME_BITS-1:0] at_ms,
                                        input logic [63:0] span);
      logic [63:0] gap;
      gap = 64'(at_ms) - 64'(since_ms);
      return (at_ms >= since_ms) && (gap >= span);
   endfunction

   task automatic apply_breaker_item(input logic [MODE_BITS-1:0] mode,
                                     input logic [ENTRY_BITS-1:0] idx,
                                     input logic failed,
                                     input logic [TIME_BITS-1:0] at_ms);
      logic [CNT_BITS-1:0] thr;
      logic [CNT_BITS-1:0] probe;
      logic [CNT_BITS-1:0] close_need;
      logic [CNT_BITS:0]   half_limit;
      logic [63:0]         sleep;
      status_type          st;
      status_type          ns;
      status_report_type   word;
      int                  first;
      thr        = (cfg_threshold != 0) ? cfg_threshold : DEF_THRESHOLD;
      sleep      = (cfg_sleep != 0) ? 64'(cfg_sleep) : 64'(DEF_SLEEP);
      probe      = (cfg_probe != 0) ? cfg_probe : DEF_PROBE;
      close_need = (cfg_close != 0) ? cfg_close : DEF_CLOSE;
      if (close_need > probe)
         close_need = probe;
      half_limit = {1'b0, probe} - {1'b0, close_need} + 1'b1;
      first      = status_reports.size();
      if (mode == MODE_SWEEP) begin
         for (int i = 0; i < ENTRIES; i++) begin
            st = entry_state[i];
            ns = st;
            if (st == ST_OPEN) begin
               if (cfg_auto_half && window_passed(state_since[i], at_ms, sleep)) begin
                  ns             = ST_HALF;
                  pass_run[i]    = '0;
                  fail_run[i]    = '0;
                  state_since[i] = at_ms;
               end
            end else if (st == ST_HALF) begin
               if (pass_run[i] >= close_need) begin
                  ns             = ST_CLOSED;
                  fail_run[i]    = '0;
                  state_since[i] = at_ms;
               end else if (window_passed(state_since[i], at_ms,
                                          64'(TIMEOUT_FACTOR) * sleep)) begin
                  ns             = ST_OPEN;
                  state_since[i] = at_ms;
               end
            end
            entry_state[i] = ns;
            // changes past the report cap still move the table
            if (ns != st && status_reports.size() - first < MAX_RESULTS) begin
               word.entry   = ENTRY_BITS'(i);
               word.status  = ns;
               word.changed = 1'b1;
               word.last    = 1'b0;
               status_reports = {status_reports, word};
            end
         end
         if (status_reports.size() > first) begin
            word      = status_reports.pop_back();
            word.last = 1'b1;
            status_reports = {status_reports, word};
         end
      end else if (mode == MODE_CALL || mode == MODE_PROBE) begin
         st = entry_state[idx];
         ns = st;
         if (mode == MODE_CALL) begin
            if (failed) begin
               if (st == ST_CLOSED) begin
                  fail_run[idx] = bump(fail_run[idx]);
                  if (fail_run[idx] >= thr) begin
                     ns               = ST_OPEN;
                     state_since[idx] = at_ms;
                  end
               end else if (st == ST_HALF) begin
                  fail_run[idx] = bump(fail_run[idx]);
                  if ({1'b0, fail_run[idx]} >= half_limit) begin
                     ns               = ST_OPEN;
                     state_since[idx] = at_ms;
                  end
               end
            end else if (st == ST_HALF) begin
               pass_run[idx] = bump(pass_run[idx]);
            end else begin
               fail_run[idx] = '0;
            end
         end else if (st == ST_OPEN) begin
            ns               = ST_HALF;
            pass_run[idx]    = '0;
            fail_run[idx]    = '0;
            state_since[idx] = at_ms;
         end
         entry_state[idx] = ns;
         word.entry   = idx;
         word.status  = ns;
         word.changed = (ns != st);
         word.last    = 1'b1;
         status_reports = {status_reports, word};
      end
   endtask

   always @(posedge clock) begin
      status_report_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            entry_state[i] = ST_CLOSED;
            fail_run[i]    = '0;
            pass_run[i]    = '0;
            state_since[i] = '0;
         end
         cfg_threshold = DEF_THRESHOLD;
         cfg_sleep     = DEF_SLEEP;
         cfg_probe     = DEF_PROBE;
         cfg_close     = DEF_CLOSE;
         cfg_auto_half = 1'b1;
         status_reports.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (status_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result word: entry %0d status %0d changed %0d last %0d",
                        $time, rsp_tdata[4:0], rsp_tdata[6:5], rsp_tdata[7], rsp_tlast);
            end else begin
               want = status_reports.pop_front();
               if (want.entry !== rsp_tdata[4:0] || want.status !== rsp_tdata[6:5] ||
                   want.changed !== rsp_tdata[7] || want.last !== rsp_tlast) begin
                  mismatch_count++;
                  $display("%0t: result mismatch: expected entry %0d status %0d changed %0d last %0d",
                           $time, want.entry, want.status, want.changed, want.last);
                  $display("%0t:                  actual entry %0d status %0d changed %0d last %0d",
                           $time, rsp_tdata[4:0], rsp_tdata[6:5], rsp_tdata[7], rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_breaker_item(req_tuser, req_tdata[ENTRY_BITS-1:0], req_tdata[ENTRY_BITS],
                               req_tdata[ENTRY_BITS+1 +: TIME_BITS]);
         if (csr_we) begin
            case (csr_addr)
               REG_ERROR_THRESHOLD: cfg_threshold = csr_wdata[CNT_BITS-1:0];
               REG_SLEEP_WINDOW:    cfg_sleep     = csr_wdata[SLEEP_BITS-1:0];
               REG_PROBE_COUNT:     cfg_probe     = csr_wdata[CNT_BITS-1:0];
               REG_CLOSE_COUNT:     cfg_close     = csr_wdata[CNT_BITS-1:0];
               REG_AUTO_HALF_OPEN:  cfg_auto_half = csr_wdata[0];
               default: ;
            endcase
         end
      end
      reports_due = status_reports.size();
   end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives call results, sweeps and probes into the circuit breaker under
// several register settings and idle patterns; ecb_checker judges every result word
// depends on ecb_pkg, ecb_checker, error_count_circuit_breaker_top
module testbench;
   import ecb_pkg::*;

   localparam int QUIET_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 1500;
   localparam int PHASE_ITEMS    = 52;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [MODE_BITS-1:0]     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int mismatch_count;
   int reports_due;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_asked    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   logic [TIME_BITS-1:0] now_ms;
   logic [TIME_BITS-1:0] stride_ms;
   logic [TIME_BITS-1:0] sleep_ms;

   error_count_circuit_breaker_top i_dut (.*);

   ecb_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, plus a long hold-off whenever one is asked for
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [TIME_BITS-1:0] rand_upto(input logic [TIME_BITS-1:0] limit);
      return TIME_BITS'({$urandom, $urandom} % (64'(limit) + 64'd1));
   endfunction

   task automatic send_request(input logic [MODE_BITS-1:0] mode,
                               input logic [ENTRY_BITS-1:0] idx,
                               input logic failed,
                               input logic [TIME_BITS-1:0] at_ms);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_BITS'({at_ms, failed, idx});
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic program_breaker(input logic [CNT_BITS-1:0] thr,
                                  input logic [SLEEP_BITS-1:0] sleep,
                                  input logic [CNT_BITS-1:0] probe,
                                  input logic [CNT_BITS-1:0] close_need,
                                  input logic auto_on);
      write_reg(REG_ERROR_THRESHOLD, CSR_DATA_BITS'(thr));
      write_reg(REG_SLEEP_WINDOW, CSR_DATA_BITS'(sleep));
      write_reg(REG_PROBE_COUNT, CSR_DATA_BITS'(probe));
      write_reg(REG_CLOSE_COUNT, CSR_DATA_BITS'(close_need));
      write_reg(REG_AUTO_HALF_OPEN, CSR_DATA_BITS'(auto_on));
      csr_we <= 1'b0;
   endtask

   // wait for every expected word, then long enough for a quiet sweep to finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [ENTRY_BITS-1:0] hot;
      logic [ENTRY_BITS-1:0] idx;
      int                    pick;
      int                    jump;
      int                    burst;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_CALL;
      csr_we     = 1'b0;
      csr_addr   = REG_ERROR_THRESHOLD;
      csr_wdata  = '0;
      now_ms     = '0;
      stride_ms  = '0;
      sleep_ms   = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: threshold 2, sleep 100, probe 3, close 2 -> half-open error limit 2
      program_breaker(16'd2, 32'd100, 16'd3, 16'd2, 1'b1);
      send_request(MODE_CALL, 5'd0, 1'b0, 48'd0);
      send_request(MODE_CALL, 5'd31, 1'b1, 48'd10);
      send_request(MODE_CALL, 5'd31, 1'b1, 48'd10);
      send_request(MODE_CALL, 5'd31, 1'b1, 48'd20);      // failure while open
      send_request(MODE_CALL, 5'd31, 1'b0, 48'd20);      // success while open
      send_request(MODE_PROBE, 5'd0, 1'b0, 48'd20);      // probe of a closed entry
      send_request(MODE_UNUSED, 5'd5, 1'b1, 48'd20);
      send_request(MODE_SWEEP, 5'd0, 1'b0, 48'd50);      // window not yet over
      send_request(MODE_SWEEP, 5'd17, 1'b1, 48'd5);      // time behind the change
      send_request(MODE_SWEEP, 5'd0, 1'b0, 48'd110);
      send_request(MODE_CALL, 5'd31, 1'b0, 48'd111);
      send_request(MODE_CALL, 5'd31, 1'b0, 48'd111);
      send_request(MODE_SWEEP, 5'd0, 1'b0, 48'd112);     // enough successes to close
      send_request(MODE_CALL, 5'd30, 1'b1, 48'd130);
      send_request(MODE_CALL, 5'd30, 1'b1, 48'd130);
      send_request(MODE_PROBE, 5'd30, 1'b0, 48'd131);
      send_request(MODE_CALL, 5'd30, 1'b1, 48'd132);
      send_request(MODE_CALL, 5'd30, 1'b1, 48'd132);     // half-open errors reopen
      send_request(MODE_PROBE, 5'd30, 1'b0, 48'd140);
      send_request(MODE_SWEEP, 5'd0, 1'b0, 48'd10140);   // half-open timeout
      send_request(MODE_CALL, 5'd0, 1'b1, 48'hFFFF_FFFF_FFFF);
      send_request(MODE_CALL, 5'd0, 1'b1, 48'hFFFF_FFFF_FFFF);
      send_request(MODE_SWEEP, 5'd0, 1'b0, 48'hFFFF_FFFF_FFFF);
      send_request(MODE_SWEEP, 5'd0, 1'b0, 48'd0);
      now_ms = 48'd20000;

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: begin
               program_breaker(16'd1, 32'd1, 16'd1, 16'd1, 1'b1);
               sleep_ms = 48'd1;  stride_ms = 48'd3;
            end
            1: begin
               program_breaker(16'd3, 32'd20, 16'd4, 16'd2, 1'b1);
               sleep_ms = 48'd20; stride_ms = 48'd30;
            end
            2: begin
               // close count above probe count gets clamped
               program_breaker(16'd2, 32'd50, 16'd3, 16'd9, 1'b0);
               sleep_ms = 48'd50; stride_ms = 48'd80;
            end
            3: begin
               // zero registers act as their reset values
               program_breaker(16'd0, 32'd0, 16'd0, 16'd0, 1'b1);
               sleep_ms = 48'd30000; stride_ms = 48'd40000;
            end
            4: begin
               program_breaker(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
               sleep_ms = 48'hFFFF_FFFF; stride_ms = 48'h1_8000_0000;
            end
            default: begin
               program_breaker(16'd4, 32'd10, 16'd6, 16'd3, 1'b1);
               sleep_ms = 48'd10; stride_ms = 48'd15;
            end
         endcase
         case (ph / 2)
            0:       begin send_idle_pct = 16; rsp_idle_pct = 65; end
            1:       begin send_idle_pct = 65; rsp_idle_pct = 16; end
            default: begin send_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         // results back up while requests keep coming
         if (ph == 4)
            hold_asked++;
         hot = ENTRY_BITS'($urandom_range(31));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            jump = $urandom_range(99);
            if (jump < 4)
               now_ms = now_ms - rand_upto(stride_ms);
            else if (jump < 8)
               now_ms = now_ms + TIMEOUT_FACTOR * sleep_ms + rand_upto(stride_ms);
            else
               now_ms = now_ms + rand_upto(stride_ms);
            pick = $urandom_range(99);
            idx  = ENTRY_BITS'(hot + $urandom_range(3));
            if (pick < 8) begin
               burst = $urandom_range(12, 1);
               repeat (burst) send_request(MODE_CALL, idx, 1'b1, now_ms);
            end else if (pick < 55) begin
               send_request(MODE_CALL, idx, ($urandom_range(99) < 70), now_ms);
            end else if (pick < 65) begin
               send_request(MODE_CALL, ENTRY_BITS'($urandom_range(31)),
                            1'($urandom_range(1)), now_ms);
            end else if (pick < 78) begin
               send_request(MODE_SWEEP, ENTRY_BITS'($urandom_range(31)),
                            1'($urandom_range(1)), now_ms);
            end else if (pick < 95) begin
               send_request(MODE_PROBE, idx, 1'($urandom_range(1)), now_ms);
            end else begin
               send_request(MODE_UNUSED, ENTRY_BITS'($urandom_range(31)),
                            1'($urandom_range(1)), now_ms);
            end
         end
      end

      settle();
      if (mismatch_count == 0 && reports_due == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
